>>> sv/putfp_pkg.sv
package putfp_pkg;

   // Store geometry and frame layout
   localparam int STORE_BYTES = 32;
   localparam int FRAME_BYTES = 12;

   // Offsets within a frame
   localparam int OFS_CHECK   = 1;
   localparam int OFS_SUM_LO  = 3;
   localparam int OFS_VOLTS   = 6;
   localparam int OFS_AMPS    = 8;
   localparam int OFS_TEMP    = 10;

   localparam logic [7:0]  CHECK_SEED  = 8'h21;
   localparam logic [15:0] VOLTS_LIMIT = 16'd600;
   localparam logic [15:0] AMPS_LIMIT  = 16'd2000;

   // Configuration register indexes
   localparam logic CSR_HEADER_BYTE = 1'b0;
   localparam logic CSR_DEVICE_ID   = 1'b1;

   // Result event codes
   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_FRAME      = 2'd1,
      EV_CHECK_FAIL = 2'd2,
      EV_OVERFLOW   = 2'd3
   } event_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [9:0]  volts_tenths;
      logic [10:0] amps_tenths;
      logic [15:0] temp_tenths;
   } rsp_word_type;

endpackage

>>> sv/putfp_word_if.sv
interface putfp_word_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/putfp_ram.sv
module putfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = putfp_pkg::STORE_BYTES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/power_unit_telemetry_frame_parser.sv
// Steps: an accepted word that leaves fewer than 12 bytes held, or that clears the store on
// overflow, goes straight to its result; otherwise the store is scanned from index 0 until the
// last frame byte, a frame start too near the end, or the last byte held, with a byte-a-cycle
// scan. A new word is taken only once the previous result is registered, plus output stalls.
// Reset (synchronous, active high) clears fill count, held values, configuration and control;
// byte store contents stay undefined and are only read below the fill count.
module power_unit_telemetry_frame_parser #(
   parameter int STORE_BYTES = putfp_pkg::STORE_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   putfp_word_if.sink   req_chan,
   putfp_word_if.source rsp_chan,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam logic [AW-1:0] FILL_LIMIT = AW'(STORE_BYTES - 1);
   localparam logic [AW-1:0] FRAME_LEN  = AW'(putfp_pkg::FRAME_BYTES);
   localparam logic [AW-1:0] LAST_OFS   = AW'(putfp_pkg::FRAME_BYTES - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 pend_ff;
   logic [AW-1:0]        idx_ff;
   logic [7:0]           w0_ff, w0_in, w1_ff, w1_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        start_ff, start_in;
   logic [7:0]           sum_ff, sum_in, ref_ff, ref_in;
   logic [7:0]           vlo_ff, vlo_in, vhi_ff, vhi_in;
   logic [7:0]           alo_ff, alo_in, ahi_ff, ahi_in, tlo_ff, tlo_in;
   putfp_pkg::event_type ev_ff, ev_in;
   logic [9:0]           volts_ff, volts_in;
   logic [10:0]          amps_ff, amps_in;
   logic [15:0]          temp_ff, temp_in;
   logic [7:0]           hdr_ff, dev_ff;
   logic                 rsp_valid_ff;
   putfp_pkg::rsp_word_type rsp_data_ff;

   logic          accept;
   logic          rd_en;
   logic [7:0]    rd_byte;
   logic [AW-1:0] new_fill;
   logic [AW-1:0] off_cur;
   logic [AW-1:0] match_pos;
   logic [7:0]    sum_final;
   logic [15:0]   volts_word, amps_word;
   logic          match;
   logic          last_byte;
   logic          rsp_free;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rd_en    = (state_ff == ST_SCAN) && (addr_ff < fill_ff);
   assign new_fill = fill_ff + 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Byte store
   putfp_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (fill_ff),
      .wr_data (req_chan.data.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_byte)
   );

   // Scan helpers on the byte arriving from the store
   assign match_pos  = idx_ff - AW'(2);
   assign match      = !found_ff && (idx_ff >= AW'(2)) && (w0_ff == hdr_ff) &&
                       (rd_byte == dev_ff);
   assign off_cur    = idx_ff - start_ff;
   assign last_byte  = (idx_ff == fill_ff - 1'b1);
   assign sum_final  = sum_ff ^ rd_byte;
   assign volts_word = {vhi_ff, vlo_ff};
   assign amps_word  = {ahi_ff, alo_ff};

   // Next-state and datapath
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      addr_in  = addr_ff;
      w0_in    = w0_ff;
      w1_in    = w1_ff;
      found_in = found_ff;
      start_in = start_ff;
      sum_in   = sum_ff;
      ref_in   = ref_ff;
      vlo_in   = vlo_ff;
      vhi_in   = vhi_ff;
      alo_in   = alo_ff;
      ahi_in   = ahi_ff;
      tlo_in   = tlo_ff;
      ev_in    = ev_ff;
      volts_in = volts_ff;
      amps_in  = amps_ff;
      temp_in  = temp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in  = '0;
               found_in = 1'b0;
               if (new_fill >= FILL_LIMIT) begin
                  fill_in  = '0;
                  ev_in    = putfp_pkg::EV_OVERFLOW;
                  state_in = ST_DONE;
               end else if (new_fill < FRAME_LEN) begin
                  fill_in  = new_fill;
                  ev_in    = putfp_pkg::EV_NONE;
                  state_in = ST_DONE;
               end else begin
                  fill_in  = new_fill;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               addr_in = addr_ff + 1'b1;
            end
            if (pend_ff) begin
               w0_in = w1_ff;
               w1_in = rd_byte;
               if (match) begin
                  // Header and id found: wait if the frame is not yet complete
                  if (fill_ff - match_pos < FRAME_LEN) begin
                     ev_in    = putfp_pkg::EV_NONE;
                     state_in = ST_DONE;
                  end else begin
                     found_in = 1'b1;
                     start_in = match_pos;
                     sum_in   = dev_ff ^ putfp_pkg::CHECK_SEED;
                     ref_in   = w1_ff;
                  end
               end else if (found_ff) begin
                  // Fold frame bytes into the checksum and catch the value words
                  if (off_cur >= AW'(putfp_pkg::OFS_SUM_LO)) begin
                     sum_in = sum_final;
                  end
                  if (off_cur == AW'(putfp_pkg::OFS_VOLTS))    vlo_in = rd_byte;
                  if (off_cur == AW'(putfp_pkg::OFS_VOLTS + 1)) vhi_in = rd_byte;
                  if (off_cur == AW'(putfp_pkg::OFS_AMPS))     alo_in = rd_byte;
                  if (off_cur == AW'(putfp_pkg::OFS_AMPS + 1))  ahi_in = rd_byte;
                  if (off_cur == AW'(putfp_pkg::OFS_TEMP))     tlo_in = rd_byte;
                  if (off_cur == LAST_OFS) begin
                     fill_in  = '0;
                     state_in = ST_DONE;
                     if (sum_final == ref_ff) begin
                        ev_in   = putfp_pkg::EV_FRAME;
                        temp_in = {rd_byte, tlo_ff};
                        if (volts_word < putfp_pkg::VOLTS_LIMIT) begin
                           volts_in = volts_word[9:0];
                        end
                        if (amps_word < putfp_pkg::AMPS_LIMIT) begin
                           amps_in = amps_word[10:0];
                        end
                     end else begin
                        ev_in = putfp_pkg::EV_CHECK_FAIL;
                     end
                  end
               end else if (last_byte) begin
                  // No frame start in the store: keep accumulating
                  ev_in    = putfp_pkg::EV_NONE;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         ev_ff        <= putfp_pkg::EV_NONE;
         volts_ff     <= '0;
         amps_ff      <= '0;
         temp_ff      <= '0;
         hdr_ff       <= '0;
         dev_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= rd_en;
         found_ff <= found_in;
         ev_ff    <= ev_in;
         volts_ff <= volts_in;
         amps_ff  <= amps_in;
         temp_ff  <= temp_in;
         // Take configuration writes
         if (csr_write_en) begin
            case (csr_index)
               putfp_pkg::CSR_HEADER_BYTE: hdr_ff <= csr_write_data;
               putfp_pkg::CSR_DEVICE_ID:   dev_ff <= csr_write_data;
               default: ;
            endcase
         end
         // Hold the result word until taken
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan payload registers
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      idx_ff   <= addr_ff;
      w0_ff    <= w0_in;
      w1_ff    <= w1_in;
      start_ff <= start_in;
      sum_ff   <= sum_in;
      ref_ff   <= ref_in;
      vlo_ff   <= vlo_in;
      vhi_ff   <= vhi_in;
      alo_ff   <= alo_in;
      ahi_ff   <= ahi_in;
      tlo_ff   <= tlo_in;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff.event_res    <= ev_ff;
         rsp_data_ff.volts_tenths <= volts_ff;
         rsp_data_ff.amps_tenths  <= amps_ff;
         rsp_data_ff.temp_tenths  <= temp_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // The fill count never reaches the overflow limit between words
   a_fill_below_limit: assert property (@(posedge clock) disable iff (reset)
      fill_ff < FILL_LIMIT)
      else $error("fill count at or beyond overflow limit");

   // Any clearing event leaves an empty store
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && ev_ff != putfp_pkg::EV_NONE) |-> fill_ff == '0)
      else $error("clearing event with non-empty store");

   // Frame bytes are only folded within the frame
   a_offset_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff && found_ff) |-> off_cur <= LAST_OFS && off_cur >= AW'(3))
      else $error("frame offset outside frame");

   // An accepted word always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted word left block idle");

endmodule
